// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the capture controller.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent holding implies the consequent in the same cycle.
`define TIC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent holding implies the consequent in the next cycle.
`define TIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/tic_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tic_pkg
// Types and constants shared by the triggered interval capture block.
// ----------------------------------------------------------------------------
package tic_pkg;

	localparam int PINS_W     = 16;
	localparam int IDX_W      = 12;
	localparam int ELAPSED_W  = 16;
	localparam int ACC_W      = 25;
	localparam int INTERVAL_W = 24;
	localparam int TIMEOUT_W  = 16;
	localparam int DEPTH_W    = 13;
	localparam int TRIG_BIT_W = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register values after reset.
	localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd7000;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 24'd16000;

	// Commands carried by an input beat.
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2
	} action_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRIG_EN   = 3'd0,
		CFG_TRIG_BIT  = 3'd1,
		CFG_TIMEOUT   = 3'd2,
		CFG_INTERVAL  = 3'd3,
		CFG_DEPTH     = 3'd4
	} cfg_reg_t;

	// Controller phase.
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_WAIT    = 2'd1,
		PH_CAPTURE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]           action;
		logic [PINS_W-1:0]    pins;
		logic [ELAPSED_W-1:0] elapsed;
	} tic_item_t;

	typedef struct packed {
		logic [PINS_W-1:0] sample_pins;
		logic [IDX_W-1:0]  sample_index;
		logic              is_sample;
		logic              last;
		logic              stopped_early;
		logic              timed_out;
	} tic_result_t;

endpackage

// ----- rtl/core/triggered_interval_capture.sv -----
`timescale 1ns / 1ps
// A result beat passes through the input register and then the result register
// after its input beat is accepted; a stalled result holds both registers.
// Throughput: one input beat per cycle; the input register and the result
// register each take a beat per cycle while the result side is not stalled.
// The combinational accumulate, saturate and compare step sets this rate.
// Reset clears the phase, the counters and the flags, and loads register defaults.
// ----------------------------------------------------------------------------
// triggered_interval_capture
// Capture controller of a logic analyzer: on start, waits for a pin change or
// a poll timeout if the trigger is enabled, then emits one pin word per sample interval.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triggered_interval_capture #(
	parameter int MAX_DEPTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  tic_pkg::tic_item_t              item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output tic_pkg::tic_result_t            result,
	input  logic                            cfg_we,
	input  logic [tic_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tic_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tic_pkg::*;

	localparam int SCNT_W    = $clog2(MAX_DEPTH + 1);
	localparam int DEPTH_CAP = (1 << DEPTH_W) - 1;
	localparam int DEPTH_RST = (MAX_DEPTH > DEPTH_CAP) ? DEPTH_CAP : MAX_DEPTH;

	// Configuration registers.
	logic                  trig_en_q;
	logic [TRIG_BIT_W-1:0] trig_bit_q;
	logic [TIMEOUT_W-1:0]  timeout_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [DEPTH_W-1:0]    depth_q;

	// Controller state.
	phase_t               phase_q, phase_d;
	logic                 ref_bit_q, ref_bit_d;
	logic                 have_ref_q, have_ref_d;
	logic [TIMEOUT_W-1:0] poll_q, poll_d;
	logic [ACC_W-1:0]     acc_q, acc_d;
	logic [SCNT_W-1:0]    scnt_q, scnt_d;
	logic                 tmo_q, tmo_d;

	// Input stage and result stage.
	logic        item_valid_s1;
	tic_item_t   item_s1;
	logic        result_valid_q;
	tic_result_t result_q;

	logic        advance;
	logic        fire;
	logic        res_valid_d;
	tic_result_t res_d;

	// Datapath intermediates.
	logic [ACC_W:0]        acc_sum;
	logic [ACC_W-1:0]      acc_sat;
	logic                  take;
	logic [ACC_W-1:0]      acc_rem;
	logic [SCNT_W-1:0]     scnt_inc;
	logic                  fin;
	logic                  trig_b;
	logic                  trig_change;
	logic                  trig_timeout;
	logic [31:0]           scnt_ext;
	logic [DEPTH_W-1:0]    depth_wr;

	// Handshake: the input stage moves on unless a held result is stalled.
	assign advance    = !(result_valid_q && result_stall);
	assign fire       = item_valid_s1 && advance;
	assign item_stall = item_valid_s1 && !advance;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Configuration writes.
	assign depth_wr = cfg_data[DEPTH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_en_q  <= 1'b0;
			trig_bit_q <= '0;
			timeout_q  <= TIMEOUT_RST;
			interval_q <= INTERVAL_RST;
			depth_q    <= DEPTH_W'(DEPTH_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRIG_EN:  trig_en_q  <= cfg_data[0];
				CFG_TRIG_BIT: trig_bit_q <= cfg_data[TRIG_BIT_W-1:0];
				CFG_TIMEOUT:  timeout_q  <= cfg_data[TIMEOUT_W-1:0];
				CFG_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
				CFG_DEPTH: begin
					// Zero or a depth beyond the buffer leaves the old depth.
					if (depth_wr != '0 && 32'(depth_wr) <= 32'(MAX_DEPTH))
						depth_q <= depth_wr;
				end
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (fire) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	// Shared arithmetic: accumulate with saturation, then test the interval.
	always_comb begin
		acc_sum      = {1'b0, acc_q} + (ACC_W + 1)'(item_s1.elapsed);
		acc_sat      = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
		take         = acc_sat >= ACC_W'(interval_q);
		acc_rem      = acc_sat - ACC_W'(interval_q);
		scnt_inc     = scnt_q + SCNT_W'(1);
		fin          = 32'(scnt_inc) >= 32'(depth_q);
		trig_b       = item_s1.pins[trig_bit_q];
		trig_change  = trig_b != ref_bit_q;
		trig_timeout = poll_q >= timeout_q;
		scnt_ext     = 32'(scnt_q);
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (item_s1.action)
			ACT_START: phase_d = trig_en_q ? PH_WAIT : PH_CAPTURE;
			ACT_STOP:  phase_d = PH_IDLE;
			ACT_TICK: begin
				unique case (phase_q)
					PH_WAIT: begin
						if (have_ref_q && (trig_change || trig_timeout))
							phase_d = PH_CAPTURE;
					end
					PH_CAPTURE: begin
						if (take && fin)
							phase_d = PH_IDLE;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Counters, flags and the result beat.
	always_comb begin
		ref_bit_d   = ref_bit_q;
		have_ref_d  = have_ref_q;
		poll_d      = poll_q;
		acc_d       = acc_q;
		scnt_d      = scnt_q;
		tmo_d       = tmo_q;
		res_valid_d = 1'b0;
		res_d       = '0;
		case (item_s1.action)
			ACT_START: begin
				ref_bit_d  = 1'b0;
				have_ref_d = 1'b0;
				poll_d     = '0;
				acc_d      = '0;
				scnt_d     = '0;
				tmo_d      = 1'b0;
			end
			ACT_STOP: begin
				// A stop while armed or capturing closes the capture.
				if (phase_q != PH_IDLE) begin
					res_valid_d         = 1'b1;
					res_d.sample_index  = scnt_ext[IDX_W-1:0];
					res_d.last          = 1'b1;
					res_d.stopped_early = 1'b1;
					res_d.timed_out     = tmo_q;
				end
			end
			ACT_TICK: begin
				unique case (phase_q)
					PH_WAIT: begin
						if (!have_ref_q) begin
							ref_bit_d  = trig_b;
							have_ref_d = 1'b1;
						end else if (trig_change) begin
							tmo_d = 1'b0;
							acc_d = '0;
						end else if (trig_timeout) begin
							tmo_d = 1'b1;
							acc_d = '0;
						end else begin
							poll_d = poll_q + TIMEOUT_W'(1);
						end
					end
					PH_CAPTURE: begin
						if (take) begin
							acc_d              = acc_rem;
							scnt_d             = scnt_inc;
							res_valid_d        = 1'b1;
							res_d.sample_pins  = item_s1.pins;
							res_d.sample_index = scnt_ext[IDX_W-1:0];
							res_d.is_sample    = 1'b1;
							res_d.last         = fin;
							res_d.timed_out    = tmo_q;
						end else begin
							acc_d = acc_sat;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// State update when the input stage hands its beat on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			ref_bit_q  <= 1'b0;
			have_ref_q <= 1'b0;
			poll_q     <= '0;
			acc_q      <= '0;
			scnt_q     <= '0;
			tmo_q      <= 1'b0;
		end else if (fire) begin
			phase_q    <= phase_d;
			ref_bit_q  <= ref_bit_d;
			have_ref_q <= have_ref_d;
			poll_q     <= poll_d;
			acc_q      <= acc_d;
			scnt_q     <= scnt_d;
			tmo_q      <= tmo_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= fire && res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid_d)
			result_q <= res_d;
	end

	// Checks.
	`TIC_ASSERT_IMPL(a_stall_only_on_held, item_stall, result_valid && result_stall,
		"input stalled while the result side is free")
	`TIC_ASSERT_IMPL(a_stop_beat_marks, result_valid && !result.is_sample,
		result.last && result.stopped_early && result.sample_pins == '0,
		"stop-only beat without last or stop mark")
	`TIC_ASSERT_IMPL(a_sample_not_stop, result_valid && result.is_sample,
		!result.stopped_early, "sample beat marked as stopped")

endmodule

// ----- sim/triggered_interval_capture_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triggered_interval_capture_tb
// Self-checking bench for the capture controller. A short directed sequence
// covers ignored commands, restarts, trigger change and timeout, zero interval
// and depth handling. Random phases then run well-formed captures with noise
// under random gaps and stalls. A long streaming capture at an interval of one
// drives the accumulator into saturation while the result side is
// held off. Every result is checked field by field against a cycle-free
// model of the controller kept in a scoreboard.
// ----------------------------------------------------------------------------
module triggered_interval_capture_tb;
	import tic_pkg::*;

	localparam int CAPTURE_MAX = 4096;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 5000;
	localparam logic [1:0] ACT_RESERVED = 2'd3;
	localparam logic [25:0] ACC_CEIL = 26'h1FFFFFF;

	// Model of the controller plus the store of expected results.
	class capture_scoreboard;
		logic        trig_en;
		logic [3:0]  trig_bit;
		logic [15:0] poll_limit;
		logic [23:0] interval;
		logic [12:0] depth;
		phase_t      phase;
		logic        ref_level;
		logic        have_ref;
		logic [15:0] polls;
		logic [24:0] acc;
		logic [12:0] taken;
		logic        by_timeout;
		tic_result_t expected_results[$];
		int          beats;
		int          samples;
		int          stops;
		int          timeouts;
		int          mismatches;

		function new();
			trig_en = 1'b0;
			trig_bit = '0;
			poll_limit = TIMEOUT_RST;
			interval = INTERVAL_RST;
			depth = 13'(CAPTURE_MAX);
			phase = PH_IDLE;
			ref_level = 1'b0;
			have_ref = 1'b0;
			polls = '0;
			acc = '0;
			taken = '0;
			by_timeout = 1'b0;
			beats = 0;
			samples = 0;
			stops = 0;
			timeouts = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Register write; an out-of-range depth leaves the old depth in place.
		function void apply_reg(cfg_reg_t idx, logic [23:0] data);
			case (idx)
				CFG_TRIG_EN:  trig_en = data[0];
				CFG_TRIG_BIT: trig_bit = data[3:0];
				CFG_TIMEOUT:  poll_limit = data[15:0];
				CFG_INTERVAL: interval = data;
				CFG_DEPTH: begin
					if (data[12:0] != 0 && data[12:0] <= CAPTURE_MAX)
						depth = data[12:0];
				end
				default: ;
			endcase
		endfunction

		// Advance the model by one accepted input beat.
		function void note_beat(tic_item_t b);
			logic        watched;
			logic        fin;
			logic [11:0] idx;
			logic [25:0] sum;
			beats++;
			case (b.action)
				ACT_START: begin
					have_ref = 1'b0;
					ref_level = 1'b0;
					polls = '0;
					acc = '0;
					taken = '0;
					by_timeout = 1'b0;
					phase = trig_en ? PH_WAIT : PH_CAPTURE;
				end
				ACT_STOP: begin
					if (phase != PH_IDLE) begin
						expected_results.push_back(tic_result_t'{16'h0000, taken[11:0],
							1'b0, 1'b1, 1'b1, by_timeout});
						phase = PH_IDLE;
					end
				end
				ACT_TICK: begin
					if (phase == PH_WAIT) begin
						watched = b.pins[trig_bit];
						if (!have_ref) begin
							ref_level = watched;
							have_ref = 1'b1;
						end else if (watched != ref_level) begin
							phase = PH_CAPTURE;
							by_timeout = 1'b0;
							acc = '0;
						end else if (polls >= poll_limit) begin
							phase = PH_CAPTURE;
							by_timeout = 1'b1;
							acc = '0;
							timeouts++;
						end else begin
							polls = polls + 16'd1;
						end
					end else if (phase == PH_CAPTURE) begin
						// Accumulate with saturation; at most one sample per tick.
						sum = {1'b0, acc} + 26'(b.elapsed);
						if (sum > ACC_CEIL)
							sum = ACC_CEIL;
						if (sum >= 26'(interval)) begin
							sum = sum - 26'(interval);
							idx = taken[11:0];
							taken = taken + 13'd1;
							fin = (taken >= depth);
							acc = sum[24:0];
							expected_results.push_back(tic_result_t'{b.pins, idx, 1'b1, fin,
								1'b0, by_timeout});
							if (fin)
								phase = PH_IDLE;
						end else begin
							acc = sum[24:0];
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		// Compare an accepted result with the oldest expectation.
		function void check_result(tic_result_t got);
			tic_result_t want;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: 0x%0h", got);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			if (want.is_sample)
				samples++;
			else
				stops++;
			compare_field("sample_pins", 32'(want.sample_pins), 32'(got.sample_pins));
			compare_field("sample_index", 32'(want.sample_index), 32'(got.sample_index));
			compare_field("is_sample", 32'(want.is_sample), 32'(got.is_sample));
			compare_field("last", 32'(want.last), 32'(got.last));
			compare_field("stopped_early", 32'(want.stopped_early), 32'(got.stopped_early));
			compare_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	tic_item_t             item = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	tic_result_t           result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	capture_scoreboard sb;
	bit          gaps_on = 1'b1;
	bit          stall_burst_req = 1'b0;
	int unsigned elapsed_span = 65535;
	int          quiet_cycles = 0;

	triggered_interval_capture uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check every result beat as it is taken.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	// Watchdog on cycles without any accepted beat or register write.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Result side: random stall runs, plus one long hold-off on request.
	initial begin
		int unsigned r;
		int unsigned run;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (stall_burst_req) begin
				stall_burst_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					result_stall <= 1'b0;
					run = $urandom_range(1, 24);
				end else begin
					result_stall <= 1'b1;
					if (r < 90)
						run = $urandom_range(1, 3);
					else if (r < 97)
						run = $urandom_range(4, 15);
					else
						run = $urandom_range(20, 80);
				end
				repeat (run) @(posedge clk);
			end
		end
	end

	function automatic int unsigned beat_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_elapsed();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 16'h0000;
		if (r < 16)
			return 16'hFFFF;
		if (r < 40)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, elapsed_span));
	endfunction

	// Offer one input beat, after a random gap, and hold it until taken.
	task automatic send_beat(logic [1:0] act, logic [15:0] p, logic [15:0] e);
		int unsigned gap;
		gap = beat_gap();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= tic_item_t'{act, p, e};
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		sb.note_beat(item);
	endtask

	// Register write, after which the enable is driven low again.
	task automatic program_reg(cfg_reg_t idx, logic [23:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.apply_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering beats and let every expected result drain out.
	task automatic drain_results();
		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Pick a full register set for one phase; upper data bits carry junk.
	task automatic configure_random();
		logic [23:0]  data;
		int unsigned  r;
		int unsigned  iv;
		data = 24'($urandom);
		data[0] = 1'($urandom_range(0, 1));
		program_reg(CFG_TRIG_EN, data);
		data = 24'($urandom);
		program_reg(CFG_TRIG_BIT, data);
		data = 24'($urandom);
		data[15:0] = ($urandom_range(0, 99) < 15) ? 16'hFFFF : 16'($urandom_range(1, 10));
		program_reg(CFG_TIMEOUT, data);
		r = $urandom_range(0, 9);
		case (r)
			0: iv = 1;
			1: iv = 0;
			2: iv = $urandom_range(1, 64);
			3, 4: iv = $urandom_range(1, 5000);
			5, 6, 7: iv = $urandom_range(1, 70000);
			8: iv = $urandom_range(100000, 300000);
			default: iv = $urandom_range(1, 2000);
		endcase
		program_reg(CFG_INTERVAL, 24'(iv));
		elapsed_span = (iv == 0) ? 200 : ((iv * 2 > 65535) ? 65535 : iv * 2);
		data = 24'($urandom);
		r = $urandom_range(0, 99);
		if (r < 15)
			data[12:0] = 13'd1;
		else if (r < 25)
			data[12:0] = 13'(CAPTURE_MAX);
		else if (r < 35)
			data[12:0] = ($urandom_range(0, 1) != 0) ? 13'd0 : 13'($urandom_range(4097, 8191));
		else
			data[12:0] = 13'($urandom_range(1, 24));
		program_reg(CFG_DEPTH, data);
	endtask

	// One capture: when armed, reference, polls and trigger; then capture ticks with noise.
	task automatic run_capture(int max_ticks);
		logic [15:0]  p;
		logic         level;
		int           n;
		int unsigned  r;
		send_beat(ACT_START, 16'($urandom), pick_elapsed());
		if (sb.phase == PH_WAIT) begin
			p = 16'($urandom);
			level = p[sb.trig_bit];
			send_beat(ACT_TICK, p, pick_elapsed());
			if (sb.poll_limit <= 12 && $urandom_range(0, 1) != 0)
				n = sb.poll_limit + 1;
			else
				n = $urandom_range(0, 6);
			repeat (n) begin
				if ($urandom_range(0, 49) == 0) begin
					send_beat(ACT_STOP, 16'($urandom), pick_elapsed());
					return;
				end
				p = 16'($urandom);
				p[sb.trig_bit] = level;
				send_beat(ACT_TICK, p, pick_elapsed());
			end
			if (sb.phase == PH_WAIT) begin
				p = 16'($urandom);
				p[sb.trig_bit] = ~level;
				send_beat(ACT_TICK, p, pick_elapsed());
			end
		end
		n = 0;
		while (sb.phase == PH_CAPTURE && n < max_ticks) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				send_beat(ACT_STOP, 16'($urandom), pick_elapsed());
			else if (r < 5)
				send_beat(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
			else
				send_beat(ACT_TICK, 16'($urandom), pick_elapsed());
			n++;
		end
	endtask

	task automatic random_phase(int goal);
		int first;
		configure_random();
		first = sb.beats;
		while (sb.beats - first < goal)
			run_capture($urandom_range(4, 40));
		send_beat(ACT_STOP, 16'($urandom), 16'($urandom));
		drain_results();
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: register defaults, ignored commands, restart, stop result.
		send_beat(ACT_STOP, 16'hFFFF, 16'hFFFF);
		send_beat(ACT_TICK, 16'hFFFF, 16'hFFFF);
		send_beat(ACT_RESERVED, 16'hFFFF, 16'hFFFF);
		send_beat(ACT_START, 16'h0000, 16'h0000);
		send_beat(ACT_TICK, 16'hFFFF, 16'hFFFF);
		send_beat(ACT_TICK, 16'h0000, 16'h0000);
		send_beat(ACT_START, 16'h0000, 16'h0000);
		send_beat(ACT_TICK, 16'hA5A5, 16'd15999);
		send_beat(ACT_TICK, 16'h5A5A, 16'd1);
		send_beat(ACT_STOP, 16'h0000, 16'h0000);
		drain_results();

		// Directed: trigger by timeout at a zero poll limit, zero interval, short depth.
		program_reg(CFG_TRIG_EN, 24'd1);
		program_reg(CFG_TRIG_BIT, 24'd15);
		program_reg(CFG_TIMEOUT, 24'd0);
		program_reg(CFG_INTERVAL, 24'd0);
		program_reg(CFG_DEPTH, 24'd3);
		send_beat(ACT_START, 16'h0000, 16'h0000);
		send_beat(ACT_TICK, 16'h8000, 16'h0000);
		send_beat(ACT_TICK, 16'hFFFF, 16'h0000);
		send_beat(ACT_TICK, 16'h1234, 16'h0000);
		send_beat(ACT_TICK, 16'hFEDC, 16'hFFFF);
		send_beat(ACT_TICK, 16'h8001, 16'h0001);
		send_beat(ACT_TICK, 16'hFFFF, 16'hFFFF);
		drain_results();

		// Directed: trigger by pin change, widest interval, rejected depth writes.
		program_reg(CFG_TRIG_BIT, 24'd0);
		program_reg(CFG_TIMEOUT, 24'hFFFF);
		program_reg(CFG_INTERVAL, 24'hFFFFFF);
		program_reg(CFG_DEPTH, 24'd0);
		program_reg(CFG_DEPTH, 24'd5000);
		send_beat(ACT_START, 16'h0000, 16'h0000);
		send_beat(ACT_TICK, 16'h0000, 16'h0000);
		send_beat(ACT_TICK, 16'h0001, 16'h0000);
		send_beat(ACT_TICK, 16'hFFFF, 16'hFFFF);
		send_beat(ACT_STOP, 16'h0000, 16'h0000);
		send_beat(ACT_START, 16'h0000, 16'h0000);
		send_beat(ACT_STOP, 16'h0000, 16'h0000);
		drain_results();

		// Random phases; every fourth one runs without input gaps.
		for (int ph = 0; ph < 14; ph++) begin
			gaps_on = (ph % 4 != 3);
			random_phase(55);
		end

		// Streaming capture at an interval of one: the accumulator saturates,
		// and the result side is held off so the block backs up its input.
		gaps_on = 1'b0;
		program_reg(CFG_TRIG_EN, 24'd0);
		program_reg(CFG_INTERVAL, 24'd1);
		program_reg(CFG_DEPTH, 24'(CAPTURE_MAX));
		stall_burst_req = 1'b1;
		send_beat(ACT_START, 16'h0000, 16'h0000);
		repeat (530)
			send_beat(ACT_TICK, 16'($urandom), 16'hFFFF);
		send_beat(ACT_STOP, 16'h0000, 16'h0000);
		drain_results();
		repeat (8) @(posedge clk);

		if (sb.pending() != 0)
			$error("%0d expected results never arrived", sb.pending());
		$display("Covered %0d input beats: %0d samples and %0d stop results checked,",
			sb.beats, sb.samples, sb.stops);
		$display("%0d captures started by timeout, and one %0d-cycle result hold-off.",
			sb.timeouts, HOLD_CYCLES);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
